>>> rtl/core/adx_pkg.sv
// Shared widths, constants and item types of the average directional index core.
package adx_pkg;

    localparam int PRICE_W        = 32;
    localparam int STATE_W        = 48;
    localparam int PCT_W          = 23;
    localparam int PER_W          = 7;
    localparam int DXS_W          = 32;
    localparam int FRAC_BITS      = 16;
    localparam int MAX_PERIOD_DEF = 64;
    localparam int NUM_W          = STATE_W + PER_W + FRAC_BITS;
    localparam int DEN_W          = STATE_W + 1;
    localparam int QCNT_W         = 6;
    localparam int ITEM_W         = 3 * PRICE_W;

    localparam logic [PER_W-1:0] RESET_PERIOD = 7'd14;
    localparam logic [PCT_W-1:0] PCT_CAP      = PCT_W'(100 << FRAC_BITS);

    // one classified bar on its way from front to back
    typedef struct packed {
        logic               first;
        logic [PRICE_W-1:0] tr;
        logic [PRICE_W-1:0] pdm;
        logic [PRICE_W-1:0] mdm;
    } bar_item_t;

    typedef struct packed {
        logic             start;
        logic             short_q;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [STATE_W-1:0] quo;
    } div_rsp_t;

endpackage

>>> rtl/core/adx_front.sv
// Front end: takes bars, forms true range and directional movement, keeps the previous bar.
module adx_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clr,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [adx_pkg::ITEM_W-1:0]  in_data,
    input  logic                        q_full,
    output logic                        q_push,
    output adx_pkg::bar_item_t          q_item
);

    logic [31:0] h, l, c;
    logic [31:0] last_high_reg, last_low_reg, last_close_reg;
    logic        have_last_reg;
    logic signed [32:0] d_hl, d_hc, d_lc, a_hc, a_lc, m1, m2, up, down;
    logic        up_wins, down_wins;

    assign h = in_data[31:0];
    assign l = in_data[63:32];
    assign c = in_data[95:64];

    assign d_hl = $signed({1'b0, h}) - $signed({1'b0, l});
    assign d_hc = $signed({1'b0, h}) - $signed({1'b0, last_close_reg});
    assign d_lc = $signed({1'b0, l}) - $signed({1'b0, last_close_reg});
    assign a_hc = d_hc[32] ? -d_hc : d_hc;
    assign a_lc = d_lc[32] ? -d_lc : d_lc;
    assign m1   = (a_hc > d_hl) ? a_hc : d_hl;
    assign m2   = (a_lc > m1) ? a_lc : m1;

    assign up        = $signed({1'b0, h}) - $signed({1'b0, last_high_reg});
    assign down      = $signed({1'b0, last_low_reg}) - $signed({1'b0, l});
    assign up_wins   = (up > down) && (up > 33'sd0);
    assign down_wins = !up_wins && (down > up) && (down > 33'sd0);

    assign in_ready     = !q_full;
    assign q_push       = in_valid && !q_full;
    assign q_item.first = !have_last_reg;
    assign q_item.tr    = m2[31:0];
    assign q_item.pdm   = up_wins ? up[31:0] : 32'd0;
    assign q_item.mdm   = down_wins ? down[31:0] : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_last_reg  <= 1'b0;
            last_high_reg  <= '0;
            last_low_reg   <= '0;
            last_close_reg <= '0;
        end
        else if (clr)
        begin
            have_last_reg  <= 1'b0;
            last_high_reg  <= '0;
            last_low_reg   <= '0;
            last_close_reg <= '0;
        end
        else if (q_push)
        begin
            have_last_reg  <= 1'b1;
            last_high_reg  <= h;
            last_low_reg   <= l;
            last_close_reg <= c;
        end
    end

endmodule

>>> rtl/core/adx_fifo.sv
// Two-entry queue between front and back.
module adx_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clr,
    input  logic               push,
    input  adx_pkg::bar_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output adx_pkg::bar_item_t head_item
);

    adx_pkg::bar_item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head_item = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else if (clr)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> rtl/core/adx_div.sv
// Shared restoring divider, one quotient bit a cycle; 48 or 23 quotient bits.
module adx_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  adx_pkg::div_req_t req,
    output adx_pkg::div_rsp_t rsp
);

    localparam int SW = adx_pkg::STATE_W;
    localparam int PW = adx_pkg::PCT_W;
    localparam int DW = adx_pkg::DEN_W;
    localparam int NW = adx_pkg::NUM_W;

    logic [DW-1:0] rem_reg, den_reg;
    logic [SW-1:0] low_reg, quo_reg;
    logic [adx_pkg::QCNT_W-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, low_reg[SW-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.den;
            quo_reg <= '0;
            if (req.short_q)
            begin
                rem_reg <= DW'(req.num[NW-1:PW]);
                low_reg <= {req.num[PW-1:0], {(SW-PW){1'b0}}};
            end
            else
            begin
                rem_reg <= DW'(req.num[NW-1:SW]);
                low_reg <= req.num[SW-1:0];
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
            low_reg <= {low_reg[SW-2:0], 1'b0};
            quo_reg <= {quo_reg[SW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.short_q ? adx_pkg::QCNT_W'(PW) : adx_pkg::QCNT_W'(SW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == adx_pkg::QCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/adx_back.sv
// Back end: smoothing, DI/DX/ADX sequencing on the shared divider, result register.
module adx_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clr,
    input  logic [adx_pkg::PER_W-1:0]  period,
    input  logic                       q_valid,
    input  adx_pkg::bar_item_t         q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [95:0]                out_data
);

    localparam int SW = adx_pkg::STATE_W;
    localparam int PW = adx_pkg::PCT_W;
    localparam int NW = adx_pkg::NUM_W;
    localparam int DW = adx_pkg::DEN_W;
    localparam int KW = adx_pkg::PER_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SMOOTH = 7'b0000010,
        S_DI     = 7'b0000100,
        S_RATIO  = 7'b0001000,
        S_DX     = 7'b0010000,
        S_DXDIV  = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    adx_pkg::bar_item_t it_reg, it_next;
    logic [SW-1:0] rs_reg, rs_next, ps_reg, ps_next, ms_reg, ms_next;
    logic [KW-1:0] cnt_reg, cnt_next, dxc_reg, dxc_next;
    logic [adx_pkg::DXS_W-1:0] ds_reg, ds_next;
    logic          seeded_reg, seeded_next, seed_reg, seed_next;
    logic          issued_reg, issued_next, diok_reg, diok_next;
    logic [1:0]    j_reg, j_next;
    logic [PW-1:0] pdi_reg, pdi_next, mdi_reg, mdi_next, dx_reg, dx_next;
    logic          ov_reg, ov_next;
    logic [95:0]   od_reg, od_next;

    adx_pkg::div_req_t dreq;
    adx_pkg::div_rsp_t drsp;

    logic [KW-1:0]    pm1;
    logic [SW-1:0]    s_sel, a_sel;
    logic [31:0]      x_sel;
    logic [DW-1:0]    b_sel, dm_sum;
    logic [SW-1:0]    dm_diff;
    logic [SW+KW-1:0] s_prod, a_prod;
    logic [NW-1:0]    smooth_num, ratio_num, dx_num;
    logic             ratio_zero, ratio_cap, ratio_trivial;
    logic [PW-1:0]    ratio_res;
    logic [1:0]       dir;
    logic             adx_ok;

    assign pm1 = period - 1'b1;

    always_comb
    begin
        case (j_reg)
            2'd0:    begin s_sel = rs_reg; x_sel = it_reg.tr;  end
            2'd1:    begin s_sel = ps_reg; x_sel = it_reg.pdm; end
            default: begin s_sel = ms_reg; x_sel = it_reg.mdm; end
        endcase
    end
    assign s_prod     = s_sel * pm1;
    assign smooth_num = seed_reg ? (NW'(s_sel) << adx_pkg::FRAC_BITS)
                                 : NW'(s_prod) + (NW'(x_sel) << adx_pkg::FRAC_BITS);

    assign dm_sum  = {1'b0, ps_reg} + {1'b0, ms_reg};
    assign dm_diff = (ps_reg > ms_reg) ? ps_reg - ms_reg : ms_reg - ps_reg;
    always_comb
    begin
        case (j_reg)
            2'd0:    begin a_sel = ps_reg;  b_sel = {1'b0, rs_reg}; end
            2'd1:    begin a_sel = ms_reg;  b_sel = {1'b0, rs_reg}; end
            default: begin a_sel = dm_diff; b_sel = dm_sum;         end
        endcase
    end
    assign a_prod        = a_sel * 7'd100;
    assign ratio_num     = {a_prod, {adx_pkg::FRAC_BITS{1'b0}}};
    assign ratio_zero    = (j_reg == 2'd2) && (dm_sum == '0);
    assign ratio_cap     = ({1'b0, a_sel} >= b_sel);
    assign ratio_trivial = ratio_zero || ratio_cap;
    assign ratio_res     = ratio_zero ? '0 : adx_pkg::PCT_CAP;

    assign dx_num = seed_reg ? NW'(ds_reg) : NW'(ds_reg * pm1) + NW'(dx_reg);

    always_comb
    begin
        dreq.start   = !issued_reg && ((state_reg == S_SMOOTH) || (state_reg == S_DXDIV)
                       || ((state_reg == S_RATIO) && !ratio_trivial));
        dreq.short_q = (state_reg != S_SMOOTH);
        dreq.den     = (state_reg == S_RATIO) ? b_sel : DW'(period);
        case (state_reg)
            S_SMOOTH: dreq.num = smooth_num;
            S_RATIO:  dreq.num = ratio_num;
            default:  dreq.num = dx_num;
        endcase
    end

    adx_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign dir    = !diok_reg ? 2'b00 : (ps_reg > ms_reg) ? 2'b01
                  : (ms_reg > ps_reg) ? 2'b11 : 2'b00;
    assign adx_ok = diok_reg && seeded_reg;

    always_comb
    begin
        state_next  = state_reg;
        it_next     = it_reg;
        rs_next     = rs_reg;
        ps_next     = ps_reg;
        ms_next     = ms_reg;
        cnt_next    = cnt_reg;
        dxc_next    = dxc_reg;
        ds_next     = ds_reg;
        seeded_next = seeded_reg;
        seed_next   = seed_reg;
        issued_next = issued_reg;
        diok_next   = diok_reg;
        j_next      = j_reg;
        pdi_next    = pdi_reg;
        mdi_next    = mdi_reg;
        dx_next     = dx_reg;
        ov_next     = ov_reg && !out_ready;
        od_next     = od_reg;
        q_pop       = 1'b0;
        if (dreq.start)
        begin
            issued_next = 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    it_next   = q_item;
                    diok_next = 1'b0;
                    j_next    = 2'd0;
                    if (q_item.first)
                    begin
                        state_next = S_OUT;
                    end
                    else if (cnt_reg < period)
                    begin
                        rs_next  = rs_reg + SW'(q_item.tr);
                        ps_next  = ps_reg + SW'(q_item.pdm);
                        ms_next  = ms_reg + SW'(q_item.mdm);
                        cnt_next = cnt_reg + 1'b1;
                        seed_next = 1'b1;
                        state_next = ({1'b0, cnt_reg} + 8'd1 >= {1'b0, period})
                                   ? S_SMOOTH : S_OUT;
                    end
                    else
                    begin
                        seed_next  = 1'b0;
                        state_next = S_SMOOTH;
                    end
                end
            end
            S_SMOOTH:
            begin
                if (drsp.done)
                begin
                    issued_next = 1'b0;
                    case (j_reg)
                        2'd0:    rs_next = drsp.quo;
                        2'd1:    ps_next = drsp.quo;
                        default: ms_next = drsp.quo;
                    endcase
                    j_next = j_reg + 1'b1;
                    if (j_reg == 2'd2)
                    begin
                        j_next     = 2'd0;
                        state_next = S_DI;
                    end
                end
            end
            S_DI:
            begin
                state_next = (rs_reg != '0) ? S_RATIO : S_OUT;
            end
            S_RATIO:
            begin
                if (ratio_trivial || drsp.done)
                begin
                    issued_next = 1'b0;
                    case (j_reg)
                        2'd0:    pdi_next = ratio_trivial ? ratio_res : drsp.quo[PW-1:0];
                        2'd1:    mdi_next = ratio_trivial ? ratio_res : drsp.quo[PW-1:0];
                        default: dx_next  = ratio_trivial ? ratio_res : drsp.quo[PW-1:0];
                    endcase
                    j_next = j_reg + 1'b1;
                    if (j_reg == 2'd2)
                    begin
                        j_next     = 2'd0;
                        state_next = S_DX;
                    end
                end
            end
            S_DX:
            begin
                diok_next = 1'b1;
                if (dxc_reg < period)
                begin
                    ds_next    = ds_reg + adx_pkg::DXS_W'(dx_reg);
                    dxc_next   = dxc_reg + 1'b1;
                    seed_next  = 1'b1;
                    state_next = ({1'b0, dxc_reg} + 8'd1 >= {1'b0, period}) ? S_DXDIV : S_OUT;
                end
                else
                begin
                    seed_next  = 1'b0;
                    state_next = S_DXDIV;
                end
            end
            S_DXDIV:
            begin
                if (drsp.done)
                begin
                    issued_next = 1'b0;
                    ds_next     = drsp.quo[adx_pkg::DXS_W-1:0];
                    if (seed_reg)
                    begin
                        seeded_next = 1'b1;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    od_next = {dir, adx_ok,
                               adx_ok ? ds_reg[PW-1:0] : {PW{1'b0}},
                               diok_reg ? dx_reg : {PW{1'b0}},
                               diok_reg,
                               diok_reg ? mdi_reg : {PW{1'b0}},
                               diok_reg ? pdi_reg : {PW{1'b0}}};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (clr)
        begin
            state_next  = S_IDLE;
            rs_next     = '0;
            ps_next     = '0;
            ms_next     = '0;
            cnt_next    = '0;
            dxc_next    = '0;
            ds_next     = '0;
            seeded_next = 1'b0;
            issued_next = 1'b0;
            ov_next     = 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        seed_reg <= seed_next;
        diok_reg <= diok_next;
        j_reg    <= j_next;
        pdi_reg  <= pdi_next;
        mdi_reg  <= mdi_next;
        dx_reg   <= dx_next;
        od_reg   <= od_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rs_reg     <= '0;
            ps_reg     <= '0;
            ms_reg     <= '0;
            cnt_reg    <= '0;
            dxc_reg    <= '0;
            ds_reg     <= '0;
            seeded_reg <= 1'b0;
            issued_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rs_reg     <= rs_next;
            ps_reg     <= ps_next;
            ms_reg     <= ms_next;
            cnt_reg    <= cnt_next;
            dxc_reg    <= dxc_next;
            ds_reg     <= ds_next;
            seeded_reg <= seeded_next;
            issued_reg <= issued_next;
            ov_reg     <= ov_next;
        end
    end

endmodule

>>> rtl/core/average_directional_index_core.sv
// Top level of the Wilder average directional index core.
// One bar (high, low, close) in, one result item out per bar. The front classifies a bar in
// the cycle it is taken and parks it in a two-item queue; the back smooths TR, +DM and -DM and
// forms +DI, -DI, DX and ADX. All divisions share one restoring divider that retires one
// quotient bit a cycle. A smoothing or seed step holds the back for the divider's start, 48
// quotient bits and done, and a DI/DX ratio or ADX step for its start, 23 bits and done. A bar
// after the seed takes the back through three smoothing steps, the DI check, three ratios and
// the DX update, then the ADX division once DX is seeded; a ratio that is zero or capped skips
// the divider, and a bar with DI invalid stops after the smoothing. The first bar and bars
// before the seed go from idle straight to output; the back takes one bar at a time.
// Writing smoothing_period clears front, queue and back as reset does; write it only while idle.
// Period 0 acts as 1, periods above MAX_PERIOD act as MAX_PERIOD.
// Results are Q.16 percent, floor rounded, DI capped at 100 percent.
module average_directional_index_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,     // smoothing_period
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // high_price[31:0], low_price[63:32], close_price[95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata   // plus_di[22:0], neg_di[45:23], di_valid[46],
                                       // dx_value[69:47], adx_level[92:70], adx_valid[93],
                                       // trend_direction[95:94]
);

    localparam logic [8:0] MAXP = 9'(adx_pkg::MAX_PERIOD_DEF);

    logic [adx_pkg::PER_W-1:0] period_reg, eff_period;
    logic                      q_push, q_full, q_pop, q_valid;
    adx_pkg::bar_item_t        push_item, head_item;

    // effective period: zero acts as one, clamp at MAX_PERIOD
    assign eff_period = (period_reg == '0) ? adx_pkg::PER_W'(1)
                      : ({2'b00, period_reg} > MAXP) ? MAXP[adx_pkg::PER_W-1:0]
                      : period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= adx_pkg::RESET_PERIOD;
        end
        else if (cfg_we)
        begin
            period_reg <= cfg_wdata;
        end
    end

    adx_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (cfg_we),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    adx_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (cfg_we),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_item (head_item)
    );

    adx_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (cfg_we),
        .period    (eff_period),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

>>> rtl/core/adx_checker.sv
// Port-level checks of the average directional index core, bound to the top level.
module adx_assertions
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && !cfg_we |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && !cfg_we |=> $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_adx_needs_di: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[93] |-> m_axis_tdata[46])
        else $error("adx_valid without di_valid");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[46] |-> m_axis_tdata[95:47] == 49'd0
            && m_axis_tdata[45:0] == 46'd0)
        else $error("invalid DI result carries non-zero fields");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[95:94] != 2'b10)
        else $error("trend_direction out of range");

endmodule

bind average_directional_index_core adx_assertions u_adx_assertions (.*);

>>> bench/adx_checker.sv
// Checker for the ADX core: watches both channels, predicts each result item and compares it.
module adx_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          di_seen,
    output int          adx_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FB  = adx_pkg::FRAC_BITS;
    localparam logic [63:0] CAP = 64'd100 << FB;
    localparam logic [63:0] MAXP = 64'(adx_pkg::MAX_PERIOD_DEF);

    typedef struct packed {
        logic               [1:0]  trend;
        logic                      adx_ok;
        logic               [22:0] adx;
        logic               [22:0] dx;
        logic                      di_ok;
        logic               [22:0] mdi;
        logic               [22:0] pdi;
    } adx_result_t;

    adx_result_t result_q[$];

    // predictor state
    logic [6:0]  period;
    logic [31:0] prev_h, prev_l, prev_c;
    logic        have_prev;
    int          bars, dx_count;
    logic [63:0] s_tr, s_pdm, s_mdm, s_dx;
    logic        adx_ready;

    function automatic logic [63:0] pct_of(logic [63:0] a, logic [63:0] b);
        logic [63:0] q, r;
        if (a >= b)
            return CAP;
        q = (a * 100) / b;
        r = (a * 100) % b;
        for (int i = 0; i < FB; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= b)
            begin
                r = r - b;
                q = q | 64'd1;
            end
        end
        return (q > CAP) ? CAP : q;
    endfunction

    function automatic logic [63:0] seed_of(logic [63:0] sum, logic [63:0] p);
        return ((sum / p) << FB) + (((sum % p) << FB) / p);
    endfunction

    function automatic logic [63:0] wilder_of(logic [63:0] s, logic [63:0] x, logic [63:0] p);
        if (x >= s)
            return s + (x - s) / p;
        return s - (s - x + p - 1) / p;
    endfunction

    task automatic clear_model();
        prev_h = '0; prev_l = '0; prev_c = '0;
        have_prev = 1'b0;
        bars = 0; dx_count = 0;
        s_tr = '0; s_pdm = '0; s_mdm = '0; s_dx = '0;
        adx_ready = 1'b0;
    endtask

    task automatic predict_bar(logic [95:0] bar);
        longint      h, l, c, tr, t, up, dn;
        logic [63:0] p, pdm, mdm, sp, sm;
        adx_result_t e;
        h = longint'(bar[31:0]);
        l = longint'(bar[63:32]);
        c = longint'(bar[95:64]);
        p = (period == 0) ? 64'd1 : (64'(period) > MAXP) ? MAXP : 64'(period);
        e = '0;
        pdm = '0;
        mdm = '0;
        if (!have_prev)
        begin
            have_prev = 1'b1;
        end
        else
        begin
            tr = h - l;
            t = h - longint'(prev_c); if (t < 0) t = -t; if (t > tr) tr = t;
            t = l - longint'(prev_c); if (t < 0) t = -t; if (t > tr) tr = t;
            up = h - longint'(prev_h);
            dn = longint'(prev_l) - l;
            if (up > dn && up > 0) pdm = 64'(up);
            else if (dn > up && dn > 0) mdm = 64'(dn);
            if (bars < p)
            begin
                s_tr += 64'(tr); s_pdm += pdm; s_mdm += mdm;
                bars++;
                if (bars >= p)
                begin
                    s_tr = seed_of(s_tr, p);
                    s_pdm = seed_of(s_pdm, p);
                    s_mdm = seed_of(s_mdm, p);
                end
            end
            else
            begin
                s_tr = wilder_of(s_tr, 64'(tr) << FB, p);
                s_pdm = wilder_of(s_pdm, pdm << FB, p);
                s_mdm = wilder_of(s_mdm, mdm << FB, p);
            end
            if (bars >= p && s_tr != 0)
            begin
                sp = s_pdm;
                sm = s_mdm;
                e.di_ok = 1'b1;
                e.pdi = 23'(pct_of(sp, s_tr));
                e.mdi = 23'(pct_of(sm, s_tr));
                if (sp + sm != 0)
                    e.dx = 23'(pct_of(sp > sm ? sp - sm : sm - sp, sp + sm));
                if (sp > sm) e.trend = 2'b01;
                else if (sm > sp) e.trend = 2'b11;
                if (dx_count < p)
                begin
                    s_dx += 64'(e.dx);
                    dx_count++;
                    if (dx_count >= p)
                    begin
                        s_dx = s_dx / p;
                        adx_ready = 1'b1;
                    end
                end
                else
                    s_dx = wilder_of(s_dx, 64'(e.dx), p);
                if (adx_ready)
                begin
                    e.adx_ok = 1'b1;
                    e.adx = 23'(s_dx);
                end
            end
        end
        prev_h = bar[31:0];
        prev_l = bar[63:32];
        prev_c = bar[95:64];
        result_q.insert(result_q.size(), e);
    endtask

    task automatic check_result(logic [95:0] got_bits);
        adx_result_t e, g;
        g = got_bits;
        if (result_q.size() == 0)
        begin
            $error("result item with nothing expected: %h", got_bits);
            fail_count++;
            return;
        end
        e = result_q.pop_front();
        if (g.pdi !== e.pdi) begin $error("plus_di exp %0d got %0d", e.pdi, g.pdi); fail_count++; end
        if (g.mdi !== e.mdi) begin $error("neg_di exp %0d got %0d", e.mdi, g.mdi); fail_count++; end
        if (g.di_ok !== e.di_ok)
        begin
            $error("di_valid exp %0b got %0b", e.di_ok, g.di_ok); fail_count++;
        end
        if (g.dx !== e.dx) begin $error("dx_value exp %0d got %0d", e.dx, g.dx); fail_count++; end
        if (g.adx !== e.adx)
        begin
            $error("adx_level exp %0d got %0d", e.adx, g.adx); fail_count++;
        end
        if (g.adx_ok !== e.adx_ok)
        begin
            $error("adx_valid exp %0b got %0b", e.adx_ok, g.adx_ok); fail_count++;
        end
        if (g.trend !== e.trend)
        begin
            $error("trend_direction exp %b got %b", e.trend, g.trend); fail_count++;
        end
        results_seen++;
        if (e.di_ok) di_seen++;
        if (e.adx_ok) adx_seen++;
    endtask

    initial
    begin
        fail_count = 0;
        results_seen = 0;
        di_seen = 0;
        adx_seen = 0;
        period = adx_pkg::RESET_PERIOD;
        clear_model();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                period = cfg_wdata;
                clear_model();
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_bar(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
        end
        pending = result_q.size();
    end

endmodule

>>> bench/testbench.sv
// Top of the ADX core testbench: clock, reset, bar stimulus, configuration and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // no-acceptance cycles allowed before the run is declared hung; the quiet time comes from a bar's
    // processing in the back, plus gaps, stalls and the idle wait before a period write
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;

    int fail_count, pending, results_seen, di_seen, adx_seen;
    int burst_left = 0;
    int quiet_cycles = 0;
    int bars_sent = 0;
    int stall_mode = 0;
    int stall_timer = 0;

    // random-walk state of the bar generator
    longint walk_px;
    longint walk_span;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    average_directional_index_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // high[31:0], low[63:32], close[95:64]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // plus_di, neg_di, di_valid, dx, adx, adx_valid, trend
    );

    adx_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .di_seen       (di_seen),
        .adx_seen      (adx_seen)
    );

    // receiver back-pressure: mode changes every so often; always ready, coin toss, long stalls
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(20, 300);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 39) == 0);
        endcase
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // one bar in; the sender may idle between bursts of random length
    task automatic send_bar(logic [31:0] h, logic [31:0] l, logic [31:0] c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c, l, h};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        bars_sent++;
    endtask

    // hold the sender until every expected result item has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // period writes only while idle; the extra cycles leave the core settled before the write
    task automatic write_period(logic [6:0] v);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] clamp_px(longint v);
        if (v < 0) return 32'd0;
        if (v > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    // mostly well-formed bars on a random walk; some pure noise and some with low above high
    task automatic random_bar();
        int     kind;
        longint h, l;
        kind = $urandom_range(0, 19);
        if (kind == 0)
            send_bar($urandom, $urandom, $urandom);
        else
        begin
            walk_px = walk_px + longint'($urandom_range(0, 32'(2 * walk_span))) - walk_span;
            if (walk_px < 0) walk_px = 0;
            if (walk_px > 64'hFFFF_FFFF) walk_px = 64'hFFFF_FFFF;
            h = walk_px + longint'($urandom_range(0, 32'(walk_span)));
            l = walk_px - longint'($urandom_range(0, 32'(walk_span)));
            if (kind == 1)
                send_bar(clamp_px(l), clamp_px(h), clamp_px(walk_px));
            else
                send_bar(clamp_px(h), clamp_px(l), clamp_px(l + (h - l) / 2));
        end
    endtask

    // new price level and volatility for a phase: near zero, mid range or near the top
    task automatic new_walk();
        case ($urandom_range(0, 3))
            0:       walk_px = $urandom_range(0, 50);
            1:       walk_px = 64'hFFFF_FFFF - $urandom_range(0, 50);
            default: walk_px = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0:       walk_span = $urandom_range(1, 4);
            1:       walk_span = $urandom_range(1, 1000);
            2:       walk_span = $urandom_range(1, 1 << 20);
            default: walk_span = 64'(32'h7FFF_FFFF);
        endcase
    endtask

    task automatic run_phase(int n, bit pause_midway);
        new_walk();
        for (int i = 0; i < n; i++)
        begin
            if (pause_midway && i == n / 2)
                drain();
            random_bar();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset period 14: first bar stored only, extremes in the seed sums
        send_bar(32'd1000, 32'd900, 32'd950);
        send_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_bar(32'd0, 32'd0, 32'd0);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'd0, 32'hFFFF_FFFF, 32'd5);             // low above high
        for (int i = 0; i < 11; i++)
            send_bar(32'd2000 + 10 * i, 32'd1900 + 10 * i, 32'd1950 + 10 * i);

        // directed, period 1
        write_period(7'd1);
        send_bar(32'd500, 32'd500, 32'd500);                 // first bar after the write
        send_bar(32'd500, 32'd500, 32'd500);                 // flat: smoothed TR zero
        send_bar(32'd500, 32'd500, 32'd500);
        send_bar(32'd510, 32'd490, 32'd500);                 // up equals down: no DM, DX zero
        send_bar(32'd600, 32'd495, 32'd590);                 // up move
        send_bar(32'd590, 32'd100, 32'd120);                 // down move
        send_bar(32'hFFFF_FFFF, 32'd0, 32'd0);               // largest range
        send_bar(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);       // malformed, largest
        send_bar(32'd10, 32'd10, 32'd10);

        // random phases across settings, the extremes among them
        run_phase(50, 1'b0);
        write_period(7'd0);                                  // acts as 1
        run_phase(40, 1'b1);
        write_period(7'd127);                                // acts as MAX_PERIOD
        run_phase(150, 1'b0);
        write_period(7'd64);
        run_phase(150, 1'b0);
        write_period(7'd2);
        run_phase(60, 1'b0);
        write_period(7'(14));
        run_phase(60, 1'b0);
        write_period(7'($urandom_range(3, 63)));
        run_phase(60, 1'b0);
        write_period(7'($urandom_range(65, 126)));
        run_phase(40, 1'b0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("bars sent %0d, results checked %0d (%0d with DI, %0d with ADX)",
                 bars_sent, results_seen, di_seen, adx_seen);
        $display("periods covered: reset value, 0, 1, 2, 14, 64, above 64 and random");
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/adx_pkg.sv
rtl/core/adx_front.sv
rtl/core/adx_fifo.sv
rtl/core/adx_div.sv
rtl/core/adx_back.sv
rtl/core/average_directional_index_core.sv
rtl/core/adx_checker.sv
bench/adx_checker.sv
bench/testbench.sv
